>>> rtl/core/scc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCTP CRC32c packet check package
// Constants, state type and the per-byte CRC32c update shared by the core.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [3:0]  HEADER_BYTES = 4'd12;
    localparam logic [3:0]  FIELD_FIRST  = 4'd8;

    typedef struct packed {
        logic [31:0] crc;
        logic [3:0]  pos;
        logic [31:0] claimed;
    } t_state;

    localparam t_state STATE_RESET = '{crc: CRC_ALL_ONES, pos: 4'd0, claimed: 32'd0};

    // Reflected CRC32c over one byte, eight bit steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/scc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCTP CRC32c packet check channels
// Valid/ready channels for datagram bytes in and check results out.
// ----------------------------------------------------------------------------
interface scc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface scc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] computed_checksum;
    logic        checksum_match;
    logic        too_short;

    modport source (output valid, output computed_checksum, output checksum_match,
                    output too_short, input ready);
    modport sink   (input valid, input computed_checksum, input checksum_match,
                    input too_short, output ready);
endinterface

>>> rtl/core/sctp_crc32c_packet_check_core.sv
`timescale 1ns / 1ps
// An accepted final byte passes the byte register, then the result register.
// Throughput: one byte word per cycle unless a held result stalls a final
// byte in the byte register; the CRC step is one unrolled byte update.
// Reset (synchronous, active low) clears the CRC to all ones, the byte count
// and the claimed checksum, and empties both registers.
// ----------------------------------------------------------------------------
// SCTP CRC32c packet check core
// Checks the CRC32c of an SCTP datagram streamed one byte per word.
// ----------------------------------------------------------------------------
module sctp_crc32c_packet_check_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scc_in_if.sink    i_in,
    scc_out_if.source o_out
);

    logic            r_s1_valid;
    logic [7:0]      r_s1_data;
    logic            r_s1_last;
    scc_pkg::t_state r_state;
    logic            r_out_valid;
    logic [31:0]     r_out_crc;
    logic            r_out_match;
    logic            r_out_short;

    scc_pkg::t_state n_state;
    logic [31:0]     n_out_crc;
    logic            n_out_match;
    logic            n_out_short;
    logic            out_free;
    logic            s1_advance;

    scc_step u_step (
        .i_state             (r_state),
        .i_data_byte         (r_s1_data),
        .i_last_byte         (r_s1_last),
        .o_state             (n_state),
        .o_computed_checksum (n_out_crc),
        .o_checksum_match    (n_out_match),
        .o_too_short         (n_out_short)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    // Hold a final byte while the previous result waits.
    assign s1_advance = r_s1_valid && (!r_s1_last || out_free);
    assign i_in.ready = !r_s1_valid || s1_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_state    <= scc_pkg::STATE_RESET;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_data <= i_in.data_byte;
            r_s1_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_last) begin
            r_out_crc   <= n_out_crc;
            r_out_match <= n_out_match;
            r_out_short <= n_out_short;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.computed_checksum = r_out_crc;
    assign o_out.checksum_match    = r_out_match;
    assign o_out.too_short         = r_out_short;

endmodule

>>> rtl/core/scc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCTP CRC32c byte step
// Folds one datagram byte into the running state and forms the result fields.
// ----------------------------------------------------------------------------
module scc_step (
    input  scc_pkg::t_state i_state,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    output scc_pkg::t_state o_state,
    output logic [31:0]     o_computed_checksum,
    output logic            o_checksum_match,
    output logic            o_too_short
);

    logic        in_field;
    logic [7:0]  fed;
    logic [31:0] crc_next;
    logic [3:0]  pos_next;
    logic [31:0] claimed_next;

    assign in_field = (i_state.pos >= scc_pkg::FIELD_FIRST)
                   && (i_state.pos < scc_pkg::HEADER_BYTES);
    // Checksum field enters the CRC as zero.
    assign fed      = in_field ? 8'd0 : i_data_byte;
    assign crc_next = scc_pkg::crc_byte(i_state.crc, fed);
    assign pos_next = (i_state.pos < scc_pkg::HEADER_BYTES) ? i_state.pos + 4'd1
                                                            : i_state.pos;

    always_comb begin
        claimed_next = i_state.claimed;
        if (in_field) begin
            case (i_state.pos[1:0])
                2'd0:    claimed_next[7:0]   = i_data_byte;
                2'd1:    claimed_next[15:8]  = i_data_byte;
                2'd2:    claimed_next[23:16] = i_data_byte;
                2'd3:    claimed_next[31:24] = i_data_byte;
                default: claimed_next        = i_state.claimed;
            endcase
        end
    end

    assign o_computed_checksum = crc_next ^ scc_pkg::CRC_ALL_ONES;
    assign o_too_short         = pos_next < scc_pkg::HEADER_BYTES;
    assign o_checksum_match    = !o_too_short && (o_computed_checksum == claimed_next);

    // Return to reset after the final byte.
    always_comb begin
        if (i_last_byte) begin
            o_state = scc_pkg::STATE_RESET;
        end else begin
            o_state.crc     = crc_next;
            o_state.pos     = pos_next;
            o_state.claimed = claimed_next;
        end
    end

endmodule
